@@ design/mmsf_pkg.sv @@
// constants and types shared by the multi-mode sensor filter
package mmsf_pkg;

    localparam int SAMPLE_BITS = 16;
    // accumulator holds a sample times a 23-bit coefficient plus headroom for three terms
    localparam int ACC_W       = SAMPLE_BITS + 26;
    // tracker arithmetic keeps two guard bits for compares and overshoot
    localparam int TRK_W       = SAMPLE_BITS + 2;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 3;
    localparam int KIND_W      = 3;
    localparam int ORDER_W     = 2;
    localparam int COUNT_W     = 4;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic signed [TRK_W-1:0]       trk_t;
    typedef logic [KIND_W-1:0]             kind_t;
    typedef logic [ORDER_W-1:0]            order_t;
    typedef logic [COUNT_W-1:0]            count_t;
    typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]         cfg_data_t;

    // register indexes
    localparam cfg_idx_t CFG_KIND  = 1'b0;
    localparam cfg_idx_t CFG_ORDER = 1'b1;

    // filter kinds
    localparam kind_t KIND_CHEB   = 3'd0;
    localparam kind_t KIND_BESSEL = 3'd1;
    localparam kind_t KIND_MEDIAN = 3'd2;
    localparam kind_t KIND_FAST   = 3'd3;
    localparam kind_t KIND_SMOOTH = 3'd4;

    // low-pass orders
    localparam order_t ORDER_ONE = 2'd1;
    localparam order_t ORDER_TWO = 2'd2;

    // first-order coefficients
    localparam acc_t CHEB1_X  = ACC_W'(3269048);
    localparam acc_t CHEB1_H  = ACC_W'(3701023);
    localparam acc_t BES1_X   = ACC_W'(2057199);
    localparam acc_t BES1_H   = ACC_W'(1068552);
    // second-order coefficients
    localparam acc_t CHEB2_X  = ACC_W'(662828);
    localparam acc_t CHEB2_H0 = ACC_W'(-540791);
    localparam acc_t CHEB2_H1 = ACC_W'(628977);
    localparam acc_t BES2_X   = ACC_W'(759505);
    localparam acc_t BES2_H0  = ACC_W'(-1011418);
    localparam acc_t BES2_H1  = ACC_W'(921678);
    // rounding terms
    localparam acc_t RND_21   = ACC_W'(1048576);
    localparam acc_t RND_20   = ACC_W'(524288);
    localparam acc_t RND_19   = ACC_W'(262144);

    // tracker constants
    localparam trk_t STEP_512 = TRK_W'(512);
    localparam trk_t STEP_128 = TRK_W'(128);
    localparam trk_t STEP_32  = TRK_W'(32);
    localparam trk_t STEP_8   = TRK_W'(8);
    localparam trk_t STEP_1   = TRK_W'(1);
    localparam count_t COUNT_MAX = 4'd10;

endpackage

@@ design/multi_mode_sensor_filter.sv @@
// multi-mode sensor filter: low-pass, median and tracker filters in one pass
//
// Each accepted sample produces exactly one filtered sample. filter_kind picks
// a Chebyshev or Bessel fixed-point low-pass filter (order 1 or 2 set by
// filter_order), a median of the last three samples, a fast binary-step
// tracker, or a smooth tracker with an accelerating step. The block has two
// register stages: an input register and a result register, with all filter
// math done by constant multiplies and adds between them. One sample is
// taken every cycle unless a full result stage with out_ready low stalls
// it; the throughput is set by the single filter datapath feeding the
// history and tracker registers, which are updated as each sample passes.
// Both stages hold their data while out_ready is low, so the input side keeps
// accepting until both are full. Configuration writes should only be issued
// while no sample is in flight; an unused kind, or an unused order with a
// low-pass kind, returns zero and leaves the filter state untouched.
module multi_mode_sensor_filter
    import mmsf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    // configuration write channel
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  cfg_idx_t  cfg_index,
    input  cfg_data_t cfg_data,
    // sample input channel
    input  logic      in_valid,
    output logic      in_ready,
    input  sample_t   sample_in,
    // filtered sample output channel
    output logic      out_valid,
    input  logic      out_ready,
    output sample_t   sample_out
);

    // configuration registers
    kind_t   filter_kind_reg;
    order_t  filter_order_reg;

    // input stage
    logic    in_valid_reg;
    sample_t sample_reg;

    // result stage
    logic    out_valid_reg;
    sample_t sample_out_reg;

    // filter state, oldest history entry at index 0
    sample_t hist0_reg, hist1_reg, hist2_reg;
    sample_t tracker_reg;
    count_t  step_count_reg;

    sample_t hist0_next, hist1_next, hist2_next;
    sample_t tracker_next;
    count_t  step_count_next;
    sample_t y_next;

    logic    calc_fire;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    // input stage moves on when the result stage is free or draining
    assign calc_fire  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !in_valid_reg || calc_fire;
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_kind_reg  <= KIND_CHEB;
            filter_order_reg <= ORDER_ONE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KIND:  filter_kind_reg  <= cfg_data[KIND_W-1:0];
                CFG_ORDER: filter_order_reg <= cfg_data[ORDER_W-1:0];
                default:   ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg <= sample_in;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (calc_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (calc_fire)
        begin
            sample_out_reg <= y_next;
        end
    end

    // filter state advances with each sample that reaches the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist0_reg      <= '0;
            hist1_reg      <= '0;
            hist2_reg      <= '0;
            tracker_reg    <= '0;
            step_count_reg <= '0;
        end
        else if (calc_fire)
        begin
            hist0_reg      <= hist0_next;
            hist1_reg      <= hist1_next;
            hist2_reg      <= hist2_next;
            tracker_reg    <= tracker_next;
            step_count_reg <= step_count_next;
        end
    end

    // filter datapath
    always_comb
    begin
        acc_t    xa, h1a, h2a, acc;
        sample_t t16;
        trk_t    xt, ht, stepv;
        count_t  cnt;
        sample_t lo, hi;

        hist0_next      = hist0_reg;
        hist1_next      = hist1_reg;
        hist2_next      = hist2_reg;
        tracker_next    = tracker_reg;
        step_count_next = step_count_reg;
        y_next          = '0;

        xa    = ACC_W'(sample_reg);
        h1a   = ACC_W'(hist1_reg);
        h2a   = ACC_W'(hist2_reg);
        acc   = '0;
        t16   = '0;
        xt    = TRK_W'(sample_reg);
        ht    = TRK_W'(tracker_reg);
        stepv = '0;
        cnt   = step_count_reg;
        lo    = '0;
        hi    = '0;

        unique case (filter_kind_reg) inside
            KIND_CHEB, KIND_BESSEL:
            begin
                if (filter_order_reg == ORDER_ONE)
                begin
                    // new oldest entry is the previous newest one
                    if (filter_kind_reg == KIND_CHEB)
                    begin
                        acc = (((xa * CHEB1_X) >>> 2) + ((h1a * CHEB1_H) >>> 3) + RND_21) >>> 21;
                    end
                    else
                    begin
                        acc = (((xa * BES1_X) >>> 3) + ((h1a * BES1_H) >>> 1) + RND_20) >>> 20;
                    end
                    t16        = acc[SAMPLE_BITS-1:0];
                    hist0_next = hist1_reg;
                    hist1_next = t16;
                    y_next     = hist1_reg + t16;
                end
                else if (filter_order_reg == ORDER_TWO)
                begin
                    if (filter_kind_reg == KIND_CHEB)
                    begin
                        acc = (((xa * CHEB2_X) >>> 4) + ((h1a * CHEB2_H0) >>> 1)
                               + (h2a * CHEB2_H1) + RND_19) >>> 19;
                    end
                    else
                    begin
                        acc = (((xa * BES2_X) >>> 4) + ((h1a * BES2_H0) >>> 3)
                               + ((h2a * BES2_H1) >>> 1) + RND_19) >>> 19;
                    end
                    t16        = acc[SAMPLE_BITS-1:0];
                    hist0_next = hist1_reg;
                    hist1_next = hist2_reg;
                    hist2_next = t16;
                    y_next     = hist1_reg + (hist2_reg <<< 1) + t16;
                end
            end

            KIND_MEDIAN:
            begin
                hist0_next = hist1_reg;
                hist1_next = hist2_reg;
                hist2_next = sample_reg;
                lo = (hist1_reg < hist2_reg) ? hist1_reg : hist2_reg;
                hi = (hist1_reg < hist2_reg) ? hist2_reg : hist1_reg;
                if (sample_reg <= lo)
                begin
                    y_next = lo;
                end
                else if (sample_reg >= hi)
                begin
                    y_next = hi;
                end
                else
                begin
                    y_next = sample_reg;
                end
            end

            KIND_FAST:
            begin
                // coarse-to-fine steps never pass the input
                if (xt > ht)
                begin
                    if (xt > ht + STEP_512) ht = ht + STEP_512;
                    if (xt > ht + STEP_128) ht = ht + STEP_128;
                    if (xt > ht + STEP_32)  ht = ht + STEP_32;
                    if (xt > ht + STEP_8)   ht = ht + STEP_8;
                    ht = ht + STEP_1;
                end
                else if (xt < ht)
                begin
                    if (xt < ht - STEP_512) ht = ht - STEP_512;
                    if (xt < ht - STEP_128) ht = ht - STEP_128;
                    if (xt < ht - STEP_32)  ht = ht - STEP_32;
                    if (xt < ht - STEP_8)   ht = ht - STEP_8;
                    ht = ht - STEP_1;
                end
                tracker_next = ht[SAMPLE_BITS-1:0];
                y_next       = ht[SAMPLE_BITS-1:0];
            end

            KIND_SMOOTH:
            begin
                // step grows by 8 each time the gap is large, may overshoot
                if (xt > ht)
                begin
                    if (xt > ht + STEP_8)
                    begin
                        cnt   = cnt + 4'd1;
                        stepv = TRK_W'({cnt, 3'b000});
                        ht    = ht + stepv;
                    end
                    ht = ht + STEP_1;
                end
                else if (xt < ht)
                begin
                    if (xt < ht - STEP_8)
                    begin
                        cnt   = cnt + 4'd1;
                        stepv = TRK_W'({cnt, 3'b000});
                        ht    = ht - stepv;
                    end
                    ht = ht - STEP_1;
                end
                if (cnt > COUNT_MAX)
                begin
                    cnt = '0;
                end
                step_count_next = cnt;
                tracker_next    = ht[SAMPLE_BITS-1:0];
                y_next          = ht[SAMPLE_BITS-1:0];
            end

            default:
            begin
                y_next = '0;
            end
        endcase
    end

endmodule
